[src/yuv420_lut_color_transform_core_macros.svh]
// Assertion macros for the color transform RTL.
`ifndef YUV420_LUT_COLOR_TRANSFORM_CORE_MACROS_SVH
`define YUV420_LUT_COLOR_TRANSFORM_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define YLTC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("yltc assertion failed");
// Check a property at every rising edge, reset included.
`define YLTC_ASSERT_RST(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("yltc reset assertion failed");
`else
`define YLTC_ASSERT(name, clk, rst, prop)
`define YLTC_ASSERT_RST(name, clk, prop)
`endif

`endif

[src/yltc_pkg.sv]
// Shared types and constants of the YUV 4:2:0 color table transform.
package yltc_pkg;

   localparam int ENTRY_INDEX_W     = 17;
   localparam int ENTRY_W           = 24;
   localparam int PIX_W             = 8;
   localparam int NUM_PIX           = 4;
   localparam int LUMA_LEVELS       = 256;
   localparam int LUMA_W            = 8;
   localparam int CHROMA_LEVELS_DEF = 17;
   localparam int REQ_TDATA_W       = 96;
   localparam int RSP_TDATA_W       = 48;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_BLOCK = 1'b1
   } kind_type;

   // Pixel order everywhere: 0 top left, 1 top right, 2 bottom left, 3 bottom right.
   typedef struct packed {
      kind_type                         kind;
      logic [ENTRY_INDEX_W-1:0]         entry_index;
      logic [ENTRY_W-1:0]               entry_data;
      logic [NUM_PIX-1:0][PIX_W-1:0]    luma;
      logic [PIX_W-1:0]                 chroma_u;
      logic [PIX_W-1:0]                 chroma_v;
      logic                             has_right;
      logic                             has_bottom;
   } req_item_type;

   typedef struct packed {
      logic [NUM_PIX-1:0][ENTRY_W-1:0]  entry;
      logic                             has_right;
      logic                             has_bottom;
   } lookup_item_type;

endpackage

[src/yuv420_lut_color_transform_core.sv]
// Top level of the YUV 4:2:0 3D color table transform.
//
// Usage: the req_ stream carries two kinds of transfer, told apart by req_tuser.
// A load transfer (req_tuser 0) writes one 24-bit entry (Y 7:0, U 15:8, V 23:16)
// of the color table at entry_index; writes beyond the table are dropped and no
// result is produced. A block transfer (req_tuser 1) carries one 2x2 luma block
// with its shared U/V codes and gives one rsp_ transfer: four mapped luma values
// (zero for absent pixels) and the rounded U/V averages over the present pixels.
// A block holds the lookup stage for a top and then a bottom pair read, as its
// four table reads share the two read ports of the table memory; load transfers
// go one per cycle while no block ahead of them stalls. Reset clears the pipeline
// valid bits and the read phase only; table contents are undefined until loaded,
// and blocks must only read loaded entries. When rsp_tready is low the result
// register holds and the stages behind it keep filling; req_tready falls only
// while the input register is full and stalled; no transfer is lost or repeated.
module yuv420_lut_color_transform_core #(
   parameter int CHROMA_LEVELS = yltc_pkg::CHROMA_LEVELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // low bit up: entry_index[17], entry_data[24], luma_top_left[8], luma_top_right[8],
   // luma_bottom_left[8], luma_bottom_right[8], chroma_u_in[8], chroma_v_in[8],
   // has_right[1], has_bottom[1], zero fill[5]
   input  logic [yltc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // kind: 0 load table entry, 1 process block
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // low bit up: mapped_top_left[8], mapped_top_right[8], mapped_bottom_left[8],
   // mapped_bottom_right[8], chroma_u_out[8], chroma_v_out[8]
   output logic [yltc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import yltc_pkg::*;

   localparam int ROW_W = $clog2(CHROMA_LEVELS * CHROMA_LEVELS);

   req_item_type     req_item;
   logic             front_valid;
   logic             front_ready;
   req_item_type     front_item;
   logic [ROW_W-1:0] front_row;
   logic             look_valid;
   logic             look_ready;
   lookup_item_type  look_item;

   // unpack the request transfer
   always_comb begin
      req_item.kind        = kind_type'(req_tuser);
      req_item.entry_index = req_tdata[16:0];
      req_item.entry_data  = req_tdata[40:17];
      req_item.luma[0]     = req_tdata[48:41];
      req_item.luma[1]     = req_tdata[56:49];
      req_item.luma[2]     = req_tdata[64:57];
      req_item.luma[3]     = req_tdata[72:65];
      req_item.chroma_u    = req_tdata[80:73];
      req_item.chroma_v    = req_tdata[88:81];
      req_item.has_right   = req_tdata[89];
      req_item.has_bottom  = req_tdata[90];
   end

   // input register, chroma quantizer and table row
   yltc_front #(
      .CHROMA_LEVELS (CHROMA_LEVELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item),
      .out_row   (front_row)
   );

   // table writes, top and bottom pair reads, read data stage
   yltc_lookup #(
      .CHROMA_LEVELS (CHROMA_LEVELS)
   ) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .in_row    (front_row),
      .out_valid (look_valid),
      .out_ready (look_ready),
      .out_item  (look_item)
   );

   // masking, sums, rounded averages and the result register
   yltc_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (look_valid),
      .in_ready  (look_ready),
      .in_item   (look_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

[src/yltc_ram.sv]
// Generic RAM: one write port, two registered read ports.
module yltc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [WIDTH-1:0]  rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the read data while no read is issued
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[src/yltc_front.sv]
// Input register and chroma quantizer stages of the color transform.
module yltc_front #(
   parameter int CHROMA_LEVELS = yltc_pkg::CHROMA_LEVELS_DEF,
   localparam int ROW_W = $clog2(CHROMA_LEVELS * CHROMA_LEVELS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  yltc_pkg::req_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output yltc_pkg::req_item_type out_item,
   output logic [ROW_W-1:0]      out_row
);
   import yltc_pkg::*;

   localparam int LEVEL_W   = $clog2(CHROMA_LEVELS);
   localparam int CODE_MAX  = 255;
   localparam int CODE_HALF = 127;
   localparam int QUANT_W   = $clog2(CODE_MAX * (CHROMA_LEVELS - 1) + CODE_HALF + 1) + 1;

   // level = (code * (levels - 1) + 127) / 255, with x / 255 as (x + (x >> 8) + 1) >> 8
   function automatic logic [LEVEL_W-1:0] quant(input logic [PIX_W-1:0] code);
      logic [QUANT_W-1:0] x;
      logic [QUANT_W-1:0] s;
      x = QUANT_W'(code) * QUANT_W'(CHROMA_LEVELS - 1) + QUANT_W'(CODE_HALF);
      s = x + (x >> PIX_W) + QUANT_W'(1);
      return s[PIX_W +: LEVEL_W];
   endfunction

   logic                a_valid_ff, a_valid_in;
   req_item_type        a_item_ff, a_item_in;
   logic                b_valid_ff, b_valid_in;
   req_item_type        b_item_ff, b_item_in;
   logic [LEVEL_W-1:0]  b_u_level_ff, b_u_level_in;
   logic [LEVEL_W-1:0]  b_v_level_ff, b_v_level_in;
   logic                a_ready;
   logic                b_ready;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      a_valid_in   = a_valid_ff;
      a_item_in    = a_item_ff;
      b_valid_in   = b_valid_ff;
      b_item_in    = b_item_ff;
      b_u_level_in = b_u_level_ff;
      b_v_level_in = b_v_level_ff;
      if (a_ready) begin
         a_valid_in = in_valid;
         if (in_valid) begin
            a_item_in = in_item;
         end
      end
      if (b_ready) begin
         b_valid_in = a_valid_ff;
         if (a_valid_ff) begin
            b_item_in    = a_item_ff;
            b_u_level_in = quant(a_item_ff.chroma_u);
            b_v_level_in = quant(a_item_ff.chroma_v);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_item_ff    <= a_item_in;
      b_item_ff    <= b_item_in;
      b_u_level_ff <= b_u_level_in;
      b_v_level_ff <= b_v_level_in;
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;
   // table row of the chroma cell: u_level * levels + v_level
   assign out_row   = ROW_W'(b_u_level_ff) * ROW_W'(CHROMA_LEVELS) + ROW_W'(b_v_level_ff);

endmodule

[src/yltc_lookup.sv]
// Table memory, read sequencing and read data stage of the color transform.
`include "yuv420_lut_color_transform_core_macros.svh"
module yltc_lookup #(
   parameter int CHROMA_LEVELS = yltc_pkg::CHROMA_LEVELS_DEF,
   localparam int ROW_W = $clog2(CHROMA_LEVELS * CHROMA_LEVELS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  yltc_pkg::req_item_type    in_item,
   input  logic [ROW_W-1:0]         in_row,
   output logic                     out_valid,
   input  logic                     out_ready,
   output yltc_pkg::lookup_item_type out_item
);
   import yltc_pkg::*;

   localparam int TABLE_DEPTH = CHROMA_LEVELS * CHROMA_LEVELS * LUMA_LEVELS;
   localparam int ADDR_W      = ROW_W + LUMA_W;

   typedef enum logic [1:0] {
      PH_TOP    = 2'b01,
      PH_BOTTOM = 2'b10
   } phase_type;

   logic                          c_valid_ff, c_valid_in;
   req_item_type                  c_item_ff, c_item_in;
   logic [ROW_W-1:0]              c_row_ff, c_row_in;
   phase_type                     c_phase_ff, c_phase_in;
   logic                          top_issued_ff, top_issued_in;
   logic [1:0][ENTRY_W-1:0]       top_entry_ff, top_entry_in;
   logic                          d_valid_ff, d_valid_in;
   logic                          d_right_ff, d_right_in;
   logic                          d_bottom_ff, d_bottom_in;

   logic                          d_free;
   logic                          c_is_block;
   logic                          top_go;
   logic                          bottom_go;
   logic                          load_go;
   logic                          c_leave;
   logic                          wr_en;
   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr_a;
   logic [ADDR_W-1:0]             rd_addr_b;
   logic [ENTRY_W-1:0]            rd_data_a;
   logic [ENTRY_W-1:0]            rd_data_b;

   // reads are issued only when the read data stage is free, so its data never gets clobbered
   assign d_free     = !d_valid_ff || out_ready;
   assign c_is_block = (c_item_ff.kind == KIND_BLOCK);
   assign top_go     = c_valid_ff && c_is_block && (c_phase_ff == PH_TOP) && d_free;
   assign bottom_go  = c_valid_ff && c_is_block && (c_phase_ff == PH_BOTTOM) && d_free;
   assign load_go    = c_valid_ff && !c_is_block;
   assign c_leave    = load_go || bottom_go;
   assign in_ready   = !c_valid_ff || c_leave;

   // drop writes beyond the table
   assign wr_en = load_go && (32'(c_item_ff.entry_index) < 32'(TABLE_DEPTH));
   assign rd_en = top_go || bottom_go;

   always_comb begin
      rd_addr_a = {c_row_ff, c_item_ff.luma[2]};
      rd_addr_b = {c_row_ff, c_item_ff.luma[3]};
      case (c_phase_ff)
         PH_TOP: begin
            rd_addr_a = {c_row_ff, c_item_ff.luma[0]};
            rd_addr_b = {c_row_ff, c_item_ff.luma[1]};
         end
         PH_BOTTOM: begin
            rd_addr_a = {c_row_ff, c_item_ff.luma[2]};
            rd_addr_b = {c_row_ff, c_item_ff.luma[3]};
         end
         default: begin
            rd_addr_a = {c_row_ff, c_item_ff.luma[2]};
            rd_addr_b = {c_row_ff, c_item_ff.luma[3]};
         end
      endcase
   end

   yltc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (ADDR_W'(c_item_ff.entry_index)),
      .wr_data   (c_item_ff.entry_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      c_valid_in    = c_valid_ff;
      c_item_in     = c_item_ff;
      c_row_in      = c_row_ff;
      c_phase_in    = c_phase_ff;
      top_issued_in = top_go;
      top_entry_in  = top_entry_ff;
      d_valid_in    = d_valid_ff;
      d_right_in    = d_right_ff;
      d_bottom_in   = d_bottom_ff;
      if (top_go) begin
         c_phase_in = PH_BOTTOM;
      end
      if (bottom_go) begin
         c_phase_in = PH_TOP;
      end
      if (in_ready) begin
         c_valid_in = in_valid;
         if (in_valid) begin
            c_item_in  = in_item;
            c_row_in   = in_row;
            c_phase_in = PH_TOP;
         end
      end
      // top pair read data shows in the cycle after its read
      if (top_issued_ff) begin
         top_entry_in = {rd_data_b, rd_data_a};
      end
      if (d_valid_ff && out_ready) begin
         d_valid_in = 1'b0;
      end
      if (bottom_go) begin
         d_valid_in  = 1'b1;
         d_right_in  = c_item_ff.has_right;
         d_bottom_in = c_item_ff.has_bottom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff    <= 1'b0;
         c_phase_ff    <= PH_TOP;
         top_issued_ff <= 1'b0;
         d_valid_ff    <= 1'b0;
      end else begin
         c_valid_ff    <= c_valid_in;
         c_phase_ff    <= c_phase_in;
         top_issued_ff <= top_issued_in;
         d_valid_ff    <= d_valid_in;
      end
      c_item_ff    <= c_item_in;
      c_row_ff     <= c_row_in;
      top_entry_ff <= top_entry_in;
      d_right_ff   <= d_right_in;
      d_bottom_ff  <= d_bottom_in;
   end

   assign out_valid           = d_valid_ff;
   assign out_item.entry[0]   = top_entry_ff[0];
   assign out_item.entry[1]   = top_entry_ff[1];
   assign out_item.entry[2]   = rd_data_a;
   assign out_item.entry[3]   = rd_data_b;
   assign out_item.has_right  = d_right_ff;
   assign out_item.has_bottom = d_bottom_ff;

   `YLTC_ASSERT(a_top_then_bottom, clock, reset, top_issued_ff |-> (c_valid_ff && c_phase_ff == PH_BOTTOM))
   `YLTC_ASSERT(a_bottom_fills_d, clock, reset, bottom_go |=> (d_valid_ff && c_phase_ff == PH_TOP))
   `YLTC_ASSERT(a_stalled_data_holds, clock, reset, (d_valid_ff && !out_ready) |=> $stable(out_item))
   `YLTC_ASSERT(a_load_in_top_phase, clock, reset, (c_valid_ff && !c_is_block) |-> (c_phase_ff == PH_TOP))
   `YLTC_ASSERT_RST(a_reset_empties, clock, reset |=> (!c_valid_ff && !d_valid_ff && !top_issued_ff))

endmodule

[src/yltc_reduce.sv]
// Pixel masking, chroma sum and rounded average stages of the color transform.
module yltc_reduce (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  yltc_pkg::lookup_item_type           in_item,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [yltc_pkg::RSP_TDATA_W-1:0]    out_data
);
   import yltc_pkg::*;

   localparam int SUM_W = PIX_W + 2;

   logic                           e_valid_ff, e_valid_in;
   logic [NUM_PIX-1:0][PIX_W-1:0]  e_luma_ff, e_luma_in;
   logic [SUM_W-1:0]               e_u_sum_ff, e_u_sum_in;
   logic [SUM_W-1:0]               e_v_sum_ff, e_v_sum_in;
   logic [1:0]                     e_shift_ff, e_shift_in;
   logic                           o_valid_ff, o_valid_in;
   logic [RSP_TDATA_W-1:0]         o_data_ff, o_data_in;

   logic                           o_ready;
   logic                           e_ready;
   logic [NUM_PIX-1:0]             present;
   logic [SUM_W-1:0]               round_add;
   logic [SUM_W-1:0]               u_avg;
   logic [SUM_W-1:0]               v_avg;

   assign o_ready  = !o_valid_ff || out_ready;
   assign e_ready  = !e_valid_ff || o_ready;
   assign in_ready = e_ready;

   assign present = {in_item.has_right & in_item.has_bottom, in_item.has_bottom,
                     in_item.has_right, 1'b1};

   // pixel count is 1, 2 or 4, so the average is a rounded right shift
   always_comb begin
      round_add = '0;
      case (e_shift_ff)
         2'd0:    round_add = SUM_W'(0);
         2'd1:    round_add = SUM_W'(1);
         2'd2:    round_add = SUM_W'(2);
         default: round_add = SUM_W'(0);
      endcase
   end

   assign u_avg = (e_u_sum_ff + round_add) >> e_shift_ff;
   assign v_avg = (e_v_sum_ff + round_add) >> e_shift_ff;

   always_comb begin
      e_valid_in = e_valid_ff;
      e_luma_in  = e_luma_ff;
      e_u_sum_in = e_u_sum_ff;
      e_v_sum_in = e_v_sum_ff;
      e_shift_in = e_shift_ff;
      o_valid_in = o_valid_ff;
      o_data_in  = o_data_ff;
      if (e_ready) begin
         e_valid_in = in_valid;
         if (in_valid) begin
            e_u_sum_in = '0;
            e_v_sum_in = '0;
            for (int i = 0; i < NUM_PIX; i++) begin
               // absent pixels map to zero and stay out of the sums
               e_luma_in[i] = present[i] ? in_item.entry[i][PIX_W-1:0] : '0;
               if (present[i]) begin
                  e_u_sum_in = e_u_sum_in + SUM_W'(in_item.entry[i][2*PIX_W-1:PIX_W]);
                  e_v_sum_in = e_v_sum_in + SUM_W'(in_item.entry[i][3*PIX_W-1:2*PIX_W]);
               end
            end
            if (in_item.has_right && in_item.has_bottom) begin
               e_shift_in = 2'd2;
            end else if (in_item.has_right || in_item.has_bottom) begin
               e_shift_in = 2'd1;
            end else begin
               e_shift_in = 2'd0;
            end
         end
      end
      if (o_ready) begin
         o_valid_in = e_valid_ff;
         if (e_valid_ff) begin
            o_data_in = {v_avg[PIX_W-1:0], u_avg[PIX_W-1:0], e_luma_ff[3], e_luma_ff[2],
                         e_luma_ff[1], e_luma_ff[0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
         o_valid_ff <= o_valid_in;
      end
      e_luma_ff  <= e_luma_in;
      e_u_sum_ff <= e_u_sum_in;
      e_v_sum_ff <= e_v_sum_in;
      e_shift_ff <= e_shift_in;
      o_data_ff  <= o_data_in;
   end

   assign out_valid = o_valid_ff;
   assign out_data  = o_data_ff;

endmodule

[bench/lut_transform_checker.sv]
// Checker for the color table transform: mirrors the table, predicts each block and compares.
`timescale 1ns / 1ps

module lut_transform_checker #(
   parameter int CHROMA_LEVELS = yltc_pkg::CHROMA_LEVELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [yltc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [yltc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output int                                blocks_in_flight,
   output int                                mismatch_count
);
   import yltc_pkg::*;

   localparam int TABLE_DEPTH = CHROMA_LEVELS * CHROMA_LEVELS * LUMA_LEVELS;

   // Same bit order as rsp_tdata: luma in the low 32 bits, then U, then V.
   typedef struct packed {
      logic [PIX_W-1:0]                v;
      logic [PIX_W-1:0]                u;
      logic [NUM_PIX-1:0][PIX_W-1:0]   luma;
   } mapped_block_type;

   logic [ENTRY_W-1:0] lut_image [TABLE_DEPTH];
   mapped_block_type   mapped_blocks_q [$];
   int                 errors_seen = 0;

   function automatic int unsigned chroma_level(input logic [PIX_W-1:0] code);
      return (int'(code) * (CHROMA_LEVELS - 1) + 127) / 255;
   endfunction

   function automatic mapped_block_type map_block(input req_item_type blk);
      mapped_block_type res;
      int unsigned      base, addr, sum_u, sum_v, count;
      logic [ENTRY_W-1:0] entry;
      logic [NUM_PIX-1:0] present;
      present = {blk.has_right & blk.has_bottom, blk.has_bottom, blk.has_right, 1'b1};
      base  = (chroma_level(blk.chroma_u) * CHROMA_LEVELS + chroma_level(blk.chroma_v))
              * LUMA_LEVELS;
      sum_u = 0;
      sum_v = 0;
      count = 0;
      for (int i = 0; i < NUM_PIX; i++) begin
         if (present[i]) begin
            addr  = base + 32'(blk.luma[i]);
            entry = (addr < TABLE_DEPTH) ? lut_image[addr] : '0;
            res.luma[i] = entry[7:0];
            sum_u += 32'(entry[15:8]);
            sum_v += 32'(entry[23:16]);
            count++;
         end else begin
            res.luma[i] = '0;
         end
      end
      res.u = PIX_W'((sum_u + count / 2) / count);
      res.v = PIX_W'((sum_v + count / 2) / count);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                              input logic [PIX_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors_seen++;
      end
   endtask

   always @(posedge clock) begin : watch
      req_item_type     item;
      mapped_block_type want;
      mapped_block_type got;
      if (!reset) begin
         // results first: a block accepted at this edge cannot answer at this edge
         if (rsp_tvalid && rsp_tready) begin
            got = mapped_block_type'(rsp_tdata);
            if (mapped_blocks_q.size() == 0) begin
               $error("rsp transfer with no block outstanding: %h", rsp_tdata);
               errors_seen++;
            end else begin
               want = mapped_blocks_q.pop_front();
               check_field("mapped_top_left",     want.luma[0], got.luma[0]);
               check_field("mapped_top_right",    want.luma[1], got.luma[1]);
               check_field("mapped_bottom_left",  want.luma[2], got.luma[2]);
               check_field("mapped_bottom_right", want.luma[3], got.luma[3]);
               check_field("chroma_u_out",        want.u,       got.u);
               check_field("chroma_v_out",        want.v,       got.v);
            end
         end
         if (req_tvalid && req_tready) begin
            item.kind        = kind_type'(req_tuser);
            item.entry_index = req_tdata[16:0];
            item.entry_data  = req_tdata[40:17];
            item.luma        = req_tdata[72:41];
            item.chroma_u    = req_tdata[80:73];
            item.chroma_v    = req_tdata[88:81];
            item.has_right   = req_tdata[89];
            item.has_bottom  = req_tdata[90];
            if (item.kind == KIND_LOAD) begin
               if (item.entry_index < TABLE_DEPTH)
                  lut_image[item.entry_index] = item.entry_data;
            end else begin
               mapped_blocks_q.push_back(map_block(item));
            end
         end
      end
      blocks_in_flight <= mapped_blocks_q.size();
      mismatch_count   <= errors_seen;
   end

endmodule

[bench/tb_yuv420_lut_color_transform_core.sv]
// Testbench top for the YUV 4:2:0 color table transform: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_yuv420_lut_color_transform_core;
   import yltc_pkg::*;

   localparam int CHROMA_LEVELS = CHROMA_LEVELS_DEF;
   localparam int TABLE_DEPTH   = CHROMA_LEVELS * CHROMA_LEVELS * LUMA_LEVELS;
   localparam int INDEX_MAX     = (1 << ENTRY_INDEX_W) - 1;
   localparam int ITEM_TARGET   = 950;
   // Margin before the verdict once the last result has come back.
   localparam int TAIL_CYCLES   = 24;
   // No transfer on either side for this long means the block is stuck.
   localparam int IDLE_LIMIT    = 2000;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   // low bit up: entry_index, entry_data, four luma codes, chroma U, chroma V,
   // has_right, has_bottom, zero fill
   logic [REQ_TDATA_W-1:0]  req_tdata;
   // kind: load entry or process block
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // low bit up: four mapped luma values, chroma U out, chroma V out
   logic [RSP_TDATA_W-1:0]  rsp_tdata;

   int                      blocks_in_flight;
   int                      mismatch_count;

   // Stimulus bookkeeping: which entries hold data, burst state, transfer count.
   bit                      loaded_entry [TABLE_DEPTH];
   int                      burst_left  = 0;
   int                      items_sent  = 0;
   int                      idle_cycles = 0;
   int unsigned             rx_cycle    = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   yuv420_lut_color_transform_core #(
      .CHROMA_LEVELS (CHROMA_LEVELS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lut_transform_checker #(
      .CHROMA_LEVELS (CHROMA_LEVELS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .blocks_in_flight (blocks_in_flight),
      .mismatch_count   (mismatch_count)
   );

   // Receiver: cycle through four stall styles in turn - always ready,
   // coin flip, mostly stalled, and a regular on-off rhythm.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[9:8])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= rx_cycle[2];
      endcase
   end

   // Watchdog: count cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("yuv420_lut_color_transform_core test failed");
            $finish;
         end
      end
   end

   // Present one item and hold it until the transfer. Bursts of random length
   // are separated by random gaps with valid low; a gap of zero chains bursts.
   task automatic push_transfer(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {5'b0, it.has_bottom, it.has_right, it.chroma_v, it.chroma_u,
                     it.luma, it.entry_data, it.entry_index};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Drop valid and hold off until every outstanding block has answered.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (blocks_in_flight != 0) @(posedge clock);
   endtask

   // Random 8-bit pixel or chroma code.
   function automatic logic [PIX_W-1:0] rand_code();
      return PIX_W'($urandom);
   endfunction

   // All fields random; callers overwrite what matters for the kind.
   function automatic req_item_type random_item();
      req_item_type it;
      it.kind        = kind_type'(1'($urandom_range(0, 1)));
      it.entry_index = ENTRY_INDEX_W'($urandom_range(0, INDEX_MAX));
      it.entry_data  = ENTRY_W'($urandom);
      it.luma        = $urandom;
      it.chroma_u    = rand_code();
      it.chroma_v    = rand_code();
      it.has_right   = 1'($urandom_range(0, 1));
      it.has_bottom  = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic send_load(input int unsigned index, input logic [ENTRY_W-1:0] data);
      req_item_type it;
      it             = random_item();
      it.kind        = KIND_LOAD;
      it.entry_index = ENTRY_INDEX_W'(index);
      it.entry_data  = data;
      push_transfer(it);
      if (index < TABLE_DEPTH)
         loaded_entry[index] = 1'b1;
   endtask

   function automatic int unsigned block_base(input logic [PIX_W-1:0] u,
                                              input logic [PIX_W-1:0] v);
      int unsigned ul, vl;
      ul = (int'(u) * (CHROMA_LEVELS - 1) + 127) / 255;
      vl = (int'(v) * (CHROMA_LEVELS - 1) + 127) / 255;
      return (ul * CHROMA_LEVELS + vl) * LUMA_LEVELS;
   endfunction

   // Load every entry the block will read that holds no data yet, and with
   // refresh set occasionally overwrite one, then send the block itself.
   task automatic send_block(input req_item_type blk, input bit refresh);
      int unsigned        base, addr;
      logic [NUM_PIX-1:0] present;
      base    = block_base(blk.chroma_u, blk.chroma_v);
      present = {blk.has_right & blk.has_bottom, blk.has_bottom, blk.has_right, 1'b1};
      for (int i = 0; i < NUM_PIX; i++) begin
         if (present[i]) begin
            addr = base + 32'(blk.luma[i]);
            if (!loaded_entry[addr] || (refresh && $urandom_range(0, 4) == 0))
               send_load(addr, ENTRY_W'($urandom));
         end
      end
      blk.kind = KIND_BLOCK;
      push_transfer(blk);
   endtask

   function automatic req_item_type make_block(
      input logic [PIX_W-1:0] u, input logic [PIX_W-1:0] v,
      input logic [PIX_W-1:0] tl, input logic [PIX_W-1:0] tr,
      input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] br,
      input logic right, input logic bottom);
      req_item_type it;
      it            = random_item();
      it.kind       = KIND_BLOCK;
      it.chroma_u   = u;
      it.chroma_v   = v;
      it.luma       = {br, bl, tr, tl};
      it.has_right  = right;
      it.has_bottom = bottom;
      return it;
   endfunction

   // Chroma codes at the ends of the range and on both sides of level steps.
   function automatic logic [PIX_W-1:0] corner_code();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd7;
         2:       return 8'd8;
         3:       return 8'd247;
         4:       return 8'd248;
         default: return 8'd255;
      endcase
   endfunction

   initial begin
      req_item_type    blk;
      int unsigned     index;
      logic [PIX_W-1:0] anchor;
      int              roll;
      bit              drained_mid;

      drained_mid = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = 1'b0;
      req_tdata   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: table corners with all-ones, all-zeros and mixed data.
      send_load(0, 24'hFFFFFF);
      send_load(255, 24'h000000);
      send_load(TABLE_DEPTH - 1, 24'hFFFFFF);
      send_load(TABLE_DEPTH - LUMA_LEVELS, 24'h807F01);
      // Loads past the end of the table must be dropped.
      send_load(TABLE_DEPTH, ENTRY_W'($urandom));
      send_load(INDEX_MAX, ENTRY_W'($urandom));
      // Full block, lone pixel, top row only, left column only, full block at top chroma codes.
      send_block(make_block(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 1'b1, 1'b1), 1'b0);
      send_block(make_block(8'd0, 8'd0, 8'd255, rand_code(), rand_code(), rand_code(),
                            1'b0, 1'b0), 1'b0);
      send_block(make_block(8'd0, 8'd0, 8'd0, 8'd255, rand_code(), rand_code(),
                            1'b1, 1'b0), 1'b0);
      send_block(make_block(8'd0, 8'd0, 8'd255, rand_code(), 8'd0, rand_code(),
                            1'b0, 1'b1), 1'b0);
      send_block(make_block(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1), 1'b0);
      // Chroma codes just below and above level steps, and a mid-range block.
      send_block(make_block(8'd7, 8'd8, rand_code(), rand_code(), rand_code(), rand_code(),
                            1'b1, 1'b0), 1'b0);
      send_block(make_block(8'd8, 8'd7, rand_code(), rand_code(), rand_code(), rand_code(),
                            1'b0, 1'b1), 1'b0);
      send_block(make_block(8'd247, 8'd248, rand_code(), rand_code(), rand_code(),
                            rand_code(), 1'b0, 1'b0), 1'b0);
      send_block(make_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1, 1'b1),
                 1'b0);
      drain_results();

      // Random: mostly blocks preceded by the loads they need, some stray loads.
      while (items_sent < ITEM_TARGET) begin
         if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
            drain_results();
            drained_mid = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            index = ($urandom_range(0, 4) == 0) ? $urandom_range(TABLE_DEPTH, INDEX_MAX)
                                                : $urandom_range(0, TABLE_DEPTH - 1);
            send_load(index, ENTRY_W'($urandom));
         end else begin
            blk      = random_item();
            blk.kind = KIND_BLOCK;
            if ($urandom_range(0, 1)) blk.chroma_u = corner_code();
            if ($urandom_range(0, 1)) blk.chroma_v = corner_code();
            case ($urandom_range(0, 5))
               0: begin
                  for (int i = 0; i < NUM_PIX; i++)
                     blk.luma[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               end
               1, 2: begin
                  // narrow luma spread so entries get read again
                  anchor = rand_code();
                  for (int i = 0; i < NUM_PIX; i++)
                     blk.luma[i] = anchor + PIX_W'($urandom_range(0, 3));
               end
               default: ;
            endcase
            send_block(blk, 1'b1);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("yuv420_lut_color_transform_core test passed");
      else
         $display("yuv420_lut_color_transform_core test failed");
      $finish;
   end

endmodule
